FILE: hw/rtl/bhq_pkg.sv
`default_nettype none

package bhq_pkg;

   // Heap depth and derived widths
   localparam int CAPACITY    = 64;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int CHILD_W     = IDX_W + 2;

   // Fixed field widths
   localparam int KEY_W       = 32;
   localparam int TAG_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      KIND_INSERT  = 1'b0,
      KIND_EXTRACT = 1'b1
   } kind_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_EXT_LOAD,
      S_DN_RD,
      S_DN_CMP,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic ins_start;   // latch new entry at tail, count up
      logic ext_start;   // read root and last, count down
      logic flag_full;
      logic flag_empty;
      logic up_rd;       // read parent of hole
      logic up_move;     // parent moves down into hole
      logic ext_load;    // capture root as result, last as moving entry
      logic dn_rd;       // read both children of hole
      logic dn_move;     // smaller child moves up into hole
      logic put_ent;     // moving entry lands in hole
      logic out_load;    // result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_less;
      logic dn_better;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bhq_datapath.sv
`default_nettype none

module bhq_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bhq_pkg::cmd_type            cmd,
   output bhq_pkg::sts_type                 sts,
   input  wire logic [bhq_pkg::KEY_W-1:0]   req_item_key,
   input  wire logic [bhq_pkg::TAG_W-1:0]   req_item_tag,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bhq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bhq_pkg::KEY_W-1:0]        rsp_out_key,
   output logic [bhq_pkg::TAG_W-1:0]        rsp_out_tag,
   output logic [bhq_pkg::COUNT_OUT_W-1:0]  rsp_count_after
);
   import bhq_pkg::*;

   entry_type              mem_ff [CAPACITY];
   entry_type              rd_a_ff;
   entry_type              rd_b_ff;
   entry_type              ent_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       count_ff;
   status_type             res_status_ff;
   entry_type              res_ent_ff;
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   entry_type              rsp_ent_ff;
   logic [CNT_W-1:0]       rsp_count_ff;

   logic [IDX_W-1:0]       parent_idx;
   logic [CHILD_W-1:0]     left_w;
   logic [CHILD_W-1:0]     right_w;
   logic [CHILD_W-1:0]     count_w;
   logic                   left_ok;
   logic                   right_ok;
   logic                   pick_left;
   logic                   pick_right;
   logic [KEY_W-1:0]       best_key;
   logic [IDX_W-1:0]       rd_a_addr;
   logic [IDX_W-1:0]       rd_b_addr;
   logic                   rd_en;
   logic                   wr_en;
   entry_type              wr_data;
   logic [IDX_W-1:0]       last_idx;

   // Index arithmetic
   assign parent_idx = (pos_ff - IDX_W'(1)) >> 1;
   assign left_w     = CHILD_W'({pos_ff, 1'b1});
   assign right_w    = left_w + CHILD_W'(1);
   assign count_w    = CHILD_W'(count_ff);
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));

   // Sift-down choice: left if strictly smaller, then right if smaller still
   assign left_ok  = left_w < count_w;
   assign right_ok = right_w < count_w;

   always_comb begin
      pick_left  = 1'b0;
      pick_right = 1'b0;
      best_key   = ent_ff.key;
      if (left_ok && (rd_a_ff.key < best_key)) begin
         pick_left = 1'b1;
         best_key  = rd_a_ff.key;
      end
      if (right_ok && (rd_b_ff.key < best_key)) begin
         pick_left  = 1'b0;
         pick_right = 1'b1;
      end
   end

   // Read ports
   always_comb begin
      rd_a_addr = parent_idx;
      rd_b_addr = last_idx;
      if (cmd.ext_start) begin
         rd_a_addr = '0;
      end else if (cmd.dn_rd) begin
         rd_a_addr = left_w[IDX_W-1:0];
         rd_b_addr = right_w[IDX_W-1:0];
      end
   end

   assign rd_en = cmd.ext_start | cmd.up_rd | cmd.dn_rd;

   // Write port: the hole at pos_ff gets a parent, a child or the moving entry
   always_comb begin
      wr_en   = cmd.up_move | cmd.dn_move | cmd.put_ent;
      wr_data = ent_ff;
      if (cmd.up_move) begin
         wr_data = rd_a_ff;
      end else if (cmd.dn_move) begin
         wr_data = pick_right ? rd_b_ff : rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[pos_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_a_addr];
         rd_b_ff <= mem_ff[rd_b_addr];
      end
   end

   // Hole position, moving entry and result
   always_ff @(posedge clock) begin
      if (cmd.ins_start) begin
         ent_ff.key    <= req_item_key;
         ent_ff.tag    <= req_item_tag;
         pos_ff        <= count_ff[IDX_W-1:0];
         res_status_ff <= ST_OK;
         res_ent_ff    <= '0;
      end
      if (cmd.ext_start) begin
         res_status_ff <= ST_OK;
      end
      if (cmd.flag_full) begin
         res_status_ff <= ST_FULL;
         res_ent_ff    <= '0;
      end
      if (cmd.flag_empty) begin
         res_status_ff <= ST_EMPTY;
         res_ent_ff    <= '0;
      end
      if (cmd.ext_load) begin
         res_ent_ff <= rd_a_ff;
         ent_ff     <= rd_b_ff;
         pos_ff     <= '0;
      end
      if (cmd.up_move) begin
         pos_ff <= parent_idx;
      end
      if (cmd.dn_move) begin
         pos_ff <= pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.ins_start) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (cmd.ext_start) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_ent_ff    <= res_ent_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_key     = rsp_ent_ff.key;
   assign rsp_out_tag     = rsp_ent_ff.tag;
   assign rsp_count_after = COUNT_OUT_W'(rsp_count_ff);

   // Status
   assign sts.full      = count_ff == CNT_W'(CAPACITY);
   assign sts.empty     = count_ff == '0;
   assign sts.pos_zero  = pos_ff == '0;
   assign sts.up_less   = ent_ff.key < rd_a_ff.key;
   assign sts.dn_better = pick_left | pick_right;
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/bhq_ctrl.sv
`default_nettype none

module bhq_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_kind,
   input  wire bhq_pkg::sts_type  sts,
   output bhq_pkg::cmd_type       cmd
);
   import bhq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      is_extract;

   assign is_extract = kind_type'(req_kind) == KIND_EXTRACT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (is_extract) begin
                  state_in = sts.empty ? S_DONE : S_EXT_LOAD;
               end else begin
                  state_in = sts.full ? S_DONE : S_INS_RD;
               end
            end
         end
         S_INS_RD: begin
            state_in = sts.pos_zero ? S_DONE : S_INS_CMP;
         end
         S_INS_CMP: begin
            state_in = sts.up_less ? S_INS_RD : S_DONE;
         end
         S_EXT_LOAD: begin
            state_in = sts.empty ? S_DONE : S_DN_RD;
         end
         S_DN_RD: begin
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            state_in = sts.dn_better ? S_DN_RD : S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (is_extract) begin
                  cmd.flag_empty = sts.empty;
                  cmd.ext_start  = ~sts.empty;
               end else begin
                  cmd.flag_full = sts.full;
                  cmd.ins_start = ~sts.full;
               end
            end
         end
         S_INS_RD: begin
            cmd.put_ent = sts.pos_zero;
            cmd.up_rd   = ~sts.pos_zero;
         end
         S_INS_CMP: begin
            cmd.up_move = sts.up_less;
            cmd.put_ent = ~sts.up_less;
         end
         S_EXT_LOAD: begin
            cmd.ext_load = 1'b1;
         end
         S_DN_RD: begin
            cmd.dn_rd = 1'b1;
         end
         S_DN_CMP: begin
            cmd.dn_move = sts.dn_better;
            cmd.put_ent = ~sts.dn_better;
         end
         S_DONE: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of up to CAPACITY (64) entries, each a
// 32-bit unsigned key and an 8-bit tag. A req_ transaction either inserts
// (kind 0) or extracts the smallest key (kind 1); every request produces
// exactly one rsp_ transaction carrying a status (ok, full and dropped,
// empty), the extracted key and tag (zero otherwise) and the entry count
// after the operation. Ties never swap, so equal keys keep heap order.
// Entries live in one memory with one write port and two registered read
// ports; sifting moves a hole through the tree, one memory write per level.
// Each heap level takes a read state, then a compare-and-write state. A
// dropped insert or an extract from an empty heap goes straight to the
// response, which waits until the output register is free.
// One request is in flight at a time; the next is accepted while the
// previous response still sits in the output register. No clearing pass is
// needed after reset.

`default_nettype none

module binary_min_heap_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_kind,
   input  wire logic [bhq_pkg::KEY_W-1:0]   req_item_key,
   input  wire logic [bhq_pkg::TAG_W-1:0]   req_item_tag,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bhq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bhq_pkg::KEY_W-1:0]        rsp_out_key,
   output logic [bhq_pkg::TAG_W-1:0]        rsp_out_tag,
   output logic [bhq_pkg::COUNT_OUT_W-1:0]  rsp_count_after
);
   import bhq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer: insert / extract / sift-up / sift-down flow
   bhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Heap memory, hole pointer, entry count and response register
   bhq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_item_key    (req_item_key),
      .req_item_tag    (req_item_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_count_after (rsp_count_after)
   );

endmodule

`default_nettype wire
